// ----- hw/rtl/corpus_word_tokenizer_core_macros.svh -----
// Assertion macros used by the checker file.
`ifndef CORPUS_WORD_TOKENIZER_CORE_MACROS_SVH
`define CORPUS_WORD_TOKENIZER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CWT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CWT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/cwt_pkg.sv -----
package cwt_pkg;

    localparam int MAX_WORD_BYTES = 64;
    localparam int STORE_DEPTH    = MAX_WORD_BYTES - 1;
    localparam int LEN_W          = $clog2(MAX_WORD_BYTES);
    localparam int ADDR_W         = $clog2(STORE_DEPTH);

    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(STORE_DEPTH);

    typedef enum logic [1:0] {
        CLS_FLUSH,
        CLS_SKIP,
        CLS_PUNCT,
        CLS_WORD
    } cwt_cls_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND,
        ST_PUNCT
    } cwt_state_t;

    typedef struct packed {
        logic accept;
        logic store;
        logic flush_start;
        logic load_word;
        logic load_punct;
    } cwt_cmd_t;

    typedef struct packed {
        cwt_cls_t cls;
        logic     len_zero;
        logic     len_full;
        logic     out_free;
        logic     is_last;
    } cwt_stat_t;

    function automatic cwt_cls_t cwt_classify(input logic [7:0] c, input logic eoi);
        cwt_cls_t cls;
        if (eoi || (c inside {8'h20, 8'h09, 8'h0A, 8'h00, 8'h0B, 8'h0C})) begin
            cls = CLS_FLUSH;
        end else if (c == 8'h0D) begin
            cls = CLS_SKIP;
        end else if (c inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60],
                               [8'h7B:8'h7E]}) begin
            cls = CLS_PUNCT;
        end else begin
            cls = CLS_WORD;
        end
        return cls;
    endfunction

    function automatic logic [7:0] cwt_lower(input logic [7:0] c);
        logic [7:0] r;
        if (c inside {[8'h41:8'h5A]}) begin
            r = c + 8'h20;
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/cwt_datapath.sv -----
module cwt_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_tdata,
    input  logic               s_tlast,
    input  cwt_pkg::cwt_cmd_t  cmd,
    output cwt_pkg::cwt_stat_t stat,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast
);

    logic [7:0] word_mem [cwt_pkg::STORE_DEPTH];

    logic [cwt_pkg::LEN_W-1:0] length_reg, length_next;
    logic [cwt_pkg::LEN_W-1:0] rd_idx_reg, rd_idx_next;
    logic [cwt_pkg::LEN_W-1:0] end_len_reg, end_len_next;
    logic [cwt_pkg::LEN_W-1:0] trim_len;
    logic [cwt_pkg::LEN_W-1:0] rd_idx_inc;
    logic [7:0]                rdata_reg;
    logic [7:0]                last1_reg, last2_reg, last3_reg;
    logic [7:0]                punct_reg;
    logic [7:0]                out_data_reg, out_data_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_valid_reg, out_valid_next;
    logic [7:0]                lower_byte;

    assign lower_byte = cwt_pkg::cwt_lower(s_tdata);
    assign rd_idx_inc = rd_idx_reg + cwt_pkg::LEN_W'(1);

    // A full word that ends inside a multi-byte UTF-8 sequence loses the partial sequence.
    always_comb begin
        trim_len = length_reg;
        if (length_reg == cwt_pkg::LEN_FULL && last1_reg[7]) begin
            if (last1_reg[7:6] == 2'b11) begin
                trim_len = length_reg - cwt_pkg::LEN_W'(1);
            end else if (last2_reg[7:5] == 3'b111) begin
                trim_len = length_reg - cwt_pkg::LEN_W'(2);
            end else if (last3_reg[7:3] == 5'b11110) begin
                trim_len = length_reg - cwt_pkg::LEN_W'(3);
            end
        end
    end

    always_comb begin
        length_next = length_reg;
        if (cmd.flush_start) begin
            length_next = '0;
        end else if (cmd.store) begin
            length_next = length_reg + cwt_pkg::LEN_W'(1);
        end
    end

    always_comb begin
        rd_idx_next  = rd_idx_reg;
        end_len_next = end_len_reg;
        if (cmd.flush_start) begin
            rd_idx_next  = '0;
            end_len_next = trim_len;
        end else if (cmd.load_word) begin
            rd_idx_next = rd_idx_inc;
        end
    end

    always_comb begin
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.load_word) begin
            out_data_next  = rdata_reg;
            out_last_next  = (rd_idx_inc == end_len_reg);
            out_valid_next = 1'b1;
        end else if (cmd.load_punct) begin
            out_data_next  = punct_reg;
            out_last_next  = 1'b1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            word_mem[length_reg[cwt_pkg::ADDR_W-1:0]] <= lower_byte;
        end
        rdata_reg <= word_mem[rd_idx_reg[cwt_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            length_reg    <= length_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        end_len_reg  <= end_len_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        if (cmd.accept) begin
            punct_reg <= s_tdata;
        end
        if (cmd.store) begin
            last1_reg <= lower_byte;
            last2_reg <= last1_reg;
            last3_reg <= last2_reg;
        end
    end

    assign stat.cls      = cwt_pkg::cwt_classify(s_tdata, s_tlast);
    assign stat.len_zero = (length_reg == '0);
    assign stat.len_full = (length_reg == cwt_pkg::LEN_FULL);
    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.is_last  = (rd_idx_inc == end_len_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- hw/rtl/cwt_ctrl.sv -----
module cwt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  cwt_pkg::cwt_stat_t stat,
    output cwt_pkg::cwt_cmd_t  cmd
);

    cwt_pkg::cwt_state_t state_reg, state_next;
    logic                pend_punct_reg, pend_punct_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cwt_pkg::ST_IDLE;
            pend_punct_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_punct_reg <= pend_punct_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        pend_punct_next = pend_punct_reg;
        cmd             = '0;
        s_tready        = 1'b0;
        case (state_reg)
            cwt_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    case (stat.cls)
                        cwt_pkg::CLS_FLUSH: begin
                            if (!stat.len_zero) begin
                                cmd.flush_start = 1'b1;
                                pend_punct_next = 1'b0;
                                state_next      = cwt_pkg::ST_READ;
                            end
                        end
                        cwt_pkg::CLS_PUNCT: begin
                            // Once a word is full, punctuation is dropped like word bytes.
                            if (stat.len_zero) begin
                                state_next = cwt_pkg::ST_PUNCT;
                            end else if (!stat.len_full) begin
                                cmd.flush_start = 1'b1;
                                pend_punct_next = 1'b1;
                                state_next      = cwt_pkg::ST_READ;
                            end
                        end
                        cwt_pkg::CLS_WORD: begin
                            cmd.store = !stat.len_full;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cwt_pkg::ST_READ: begin
                state_next = cwt_pkg::ST_SEND;
            end
            cwt_pkg::ST_SEND: begin
                if (stat.out_free) begin
                    cmd.load_word = 1'b1;
                    if (!stat.is_last) begin
                        state_next = cwt_pkg::ST_READ;
                    end else if (pend_punct_reg) begin
                        state_next = cwt_pkg::ST_PUNCT;
                    end else begin
                        state_next = cwt_pkg::ST_IDLE;
                    end
                end
            end
            cwt_pkg::ST_PUNCT: begin
                if (stat.out_free) begin
                    cmd.load_punct = 1'b1;
                    state_next     = cwt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cwt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/corpus_word_tokenizer_core.sv -----
// Order: a word byte is stored in the cycle it is accepted; after a separator, a flush
// passes READ and SEND before its first word loads; lone punctuation loads from PUNCT.
// Throughput: one input word per cycle while a token builds; during a flush each stored
// byte takes a store read (READ) and an output load (SEND, held while the output stalls),
// and no input is accepted. Reset: aresetn is synchronous and clears the word length,
// output valid and control state; the word store is not cleared and needs no clearing pass.
module corpus_word_tokenizer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // last_of_token
);

    cwt_pkg::cwt_cmd_t  cmd;
    cwt_pkg::cwt_stat_t stat;

    cwt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cwt_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hw/rtl/cwt_checker.sv -----
`include "corpus_word_tokenizer_core_macros.svh"

module cwt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled output word holds.
    `CWT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")

    // Input is only taken while idle, and the idle state never loads the output.
    `CWT_ASSERT_NEXT(a_no_load_on_accept, s_tvalid && s_tready, !$rose(m_tvalid), "output loaded in the cycle after an input word")

    // Emitted punctuation always forms a token of its own.
    `CWT_ASSERT_SAME(a_punct_last, m_tvalid && ((m_tdata >= 8'h21 && m_tdata <= 8'h2F) || (m_tdata >= 8'h3A && m_tdata <= 8'h40) || (m_tdata >= 8'h5B && m_tdata <= 8'h60) || (m_tdata >= 8'h7B && m_tdata <= 8'h7E)), m_tlast, "punctuation emitted without last mark")

    // Capitals, separators and CR never reach the output.
    `CWT_ASSERT_SAME(a_out_clean, m_tvalid, !(m_tdata >= 8'h41 && m_tdata <= 8'h5A) && m_tdata != 8'h20 && m_tdata != 8'h09 && m_tdata != 8'h0A && m_tdata != 8'h00 && m_tdata != 8'h0B && m_tdata != 8'h0C && m_tdata != 8'h0D, "capital or separator emitted")

endmodule

bind corpus_word_tokenizer_core cwt_checker u_cwt_checker (.*);
